// ===== rtl/mbp_pkg.sv =====
// Shared types and constants for the MSB-first bit packer.
`default_nettype none

package mbp_pkg;

    localparam int WordBits  = 64;
    localparam int WidthW    = 7;
    localparam int FillW     = 6;
    localparam int StatusW   = 2;
    localparam int TotalW    = 32;
    localparam int FifoDepth = 4;
    localparam int FifoAw    = 2;
    localparam int FifoCntW  = 3;

    localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
    localparam logic [StatusW-1:0] STATUS_BAD_WIDTH = 2'd1;
    localparam logic [StatusW-1:0] STATUS_TOO_LARGE = 2'd2;

    localparam logic [WidthW-1:0] FULL_BITS = 7'd64;

    typedef struct packed {
        logic [WordBits-1:0] word;
        logic [WidthW-1:0]   valid_bits;
        logic [StatusW-1:0]  status;
        logic [TotalW-1:0]   value_count;
        logic                final_res;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

// ===== rtl/mbp_core.sv =====
// Packing datapath: accumulator state and result generation for one transaction.
`default_nettype none

module mbp_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic [mbp_pkg::WordBits-1:0]  value,
    input  wire logic [mbp_pkg::WidthW-1:0]    width,
    input  wire logic                          flush,
    output mbp_pkg::push_t                     push
);

    logic [mbp_pkg::WordBits-1:0] acc_reg;
    logic [mbp_pkg::WordBits-1:0] acc_next;
    logic [mbp_pkg::FillW-1:0]    fill_reg;
    logic [mbp_pkg::FillW-1:0]    fill_next;
    logic [mbp_pkg::TotalW-1:0]   total_reg;
    logic [mbp_pkg::TotalW-1:0]   total_next;

    logic                         bad_width;
    logic                         too_large;
    logic [mbp_pkg::WidthW-1:0]   sum;
    logic                         word_done;
    logic [mbp_pkg::WidthW-1:0]   spill;
    logic [mbp_pkg::WidthW-1:0]   lshift;
    logic [mbp_pkg::WidthW-1:0]   cshift;
    logic [mbp_pkg::WordBits-1:0] word_full;
    logic [mbp_pkg::WordBits-1:0] acc_low;
    logic [mbp_pkg::WordBits-1:0] acc_carry;
    logic [mbp_pkg::WordBits-1:0] acc_after;
    logic [mbp_pkg::FillW-1:0]    fill_after;
    logic                         emit_flush;
    logic [mbp_pkg::TotalW-1:0]   total_inc;
    mbp_pkg::result_t             full_res;
    mbp_pkg::result_t             part_res;
    mbp_pkg::result_t             err_res;

    always_comb
    begin
        bad_width  = (width == '0) || (width > mbp_pkg::FULL_BITS);
        too_large  = !bad_width && (width < mbp_pkg::FULL_BITS) &&
                     ((value & ({mbp_pkg::WordBits{1'b1}} << width[5:0])) != '0);
        sum        = {1'b0, fill_reg} + width;
        word_done  = (sum >= mbp_pkg::FULL_BITS);
        spill      = word_done ? (sum - mbp_pkg::FULL_BITS) : '0;
        lshift     = mbp_pkg::FULL_BITS - sum;
        cshift     = mbp_pkg::FULL_BITS - spill;
        word_full  = acc_reg | (value >> spill[5:0]);
        acc_low    = acc_reg | (value << lshift[5:0]);
        acc_carry  = (spill != '0) ? (value << cshift[5:0]) : '0;
        acc_after  = word_done ? acc_carry : acc_low;
        fill_after = word_done ? spill[5:0] : sum[5:0];
        emit_flush = flush && (fill_after != '0);
        total_inc  = total_reg + 1'b1;

        full_res.word        = word_full;
        full_res.valid_bits  = mbp_pkg::FULL_BITS;
        full_res.status      = mbp_pkg::STATUS_OK;
        full_res.value_count = total_inc;
        full_res.final_res   = !emit_flush;

        part_res.word        = acc_after;
        part_res.valid_bits  = {1'b0, fill_after};
        part_res.status      = mbp_pkg::STATUS_OK;
        part_res.value_count = total_inc;
        part_res.final_res   = 1'b1;

        err_res.word         = '0;
        err_res.valid_bits   = '0;
        err_res.status       = bad_width ? mbp_pkg::STATUS_BAD_WIDTH
                                         : mbp_pkg::STATUS_TOO_LARGE;
        err_res.value_count  = total_reg;
        err_res.final_res    = 1'b1;

        push.count  = 2'd0;
        push.first  = full_res;
        push.second = part_res;
        acc_next    = acc_reg;
        fill_next   = fill_reg;
        total_next  = total_reg;

        if (fire)
        begin
            if (bad_width || too_large)
            begin
                push.count = 2'd1;
                push.first = err_res;
            end
            else
            begin
                total_next = total_inc;
                acc_next   = emit_flush ? '0 : acc_after;
                fill_next  = emit_flush ? '0 : fill_after;
                if (word_done && emit_flush)
                    push.count = 2'd2;
                else if (word_done)
                    push.count = 2'd1;
                else if (emit_flush)
                begin
                    push.count = 2'd1;
                    push.first = part_res;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            fill_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mbp_out_fifo.sv =====
// Four-entry result queue taking up to two results per cycle.
`default_nettype none

module mbp_out_fifo (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mbp_pkg::push_t push,
    input  wire logic      pop,
    output logic           room2,
    output logic           not_empty,
    output mbp_pkg::result_t head
);

    mbp_pkg::result_t            mem [mbp_pkg::FifoDepth];
    logic [mbp_pkg::FifoAw-1:0]   wp_reg;
    logic [mbp_pkg::FifoAw-1:0]   wp_next;
    logic [mbp_pkg::FifoAw-1:0]   wp_inc;
    logic [mbp_pkg::FifoAw-1:0]   rp_reg;
    logic [mbp_pkg::FifoAw-1:0]   rp_next;
    logic [mbp_pkg::FifoCntW-1:0] cnt_reg;
    logic [mbp_pkg::FifoCntW-1:0] cnt_next;

    always_comb
    begin
        wp_inc    = wp_reg + 1'b1;
        wp_next   = wp_reg + push.count;
        rp_next   = rp_reg + {{(mbp_pkg::FifoAw-1){1'b0}}, pop};
        cnt_next  = cnt_reg + {1'b0, push.count} - {{(mbp_pkg::FifoCntW-1){1'b0}}, pop};
        room2     = (cnt_reg <= 3'd2);
        not_empty = (cnt_reg != '0);
        head      = mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wp_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wp_inc] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/msb_first_bit_packer.sv =====
// Top level of the MSB-first variable-length bit packer.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  item    | item_valid, item_stall | value, width, flush
//  res     | res_valid, res_stall   | word, valid_bits, status, value_count, final_res
//
// One transaction is accepted per cycle while item_stall is low; it is registered, packed
// once the queue has room for two results, and its zero to two results enter a four-entry
// result queue, read out one at a time while res_stall is low. Two results take two
// entries; item_stall rises while the input register is full and the queue has fewer
// than two free slots. Reset clears the accumulator, bit count and value count.
`default_nettype none

module msb_first_bit_packer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic [mbp_pkg::WordBits-1:0] value,
    input  wire logic [mbp_pkg::WidthW-1:0]   width,
    input  wire logic                         flush,
    output logic                              res_valid,
    input  wire logic                         res_stall,
    output logic [mbp_pkg::WordBits-1:0]      word,
    output logic [mbp_pkg::WidthW-1:0]        valid_bits,
    output logic [mbp_pkg::StatusW-1:0]       status,
    output logic [mbp_pkg::TotalW-1:0]        value_count,
    output logic                              final_res
);

    logic                         vld_reg;
    logic [mbp_pkg::WordBits-1:0] value_reg;
    logic [mbp_pkg::WidthW-1:0]   width_reg;
    logic                         flush_reg;
    logic                         fire;
    logic                         room2;
    logic                         not_empty;
    logic                         pop;
    mbp_pkg::push_t               push;
    mbp_pkg::result_t             head;

    assign fire       = vld_reg && room2;
    assign item_stall = vld_reg && !room2;
    assign pop        = not_empty && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (!item_stall)
            vld_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            value_reg <= value;
            width_reg <= width;
            flush_reg <= flush;
        end
    end

    mbp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .value (value_reg),
        .width (width_reg),
        .flush (flush_reg),
        .push  (push)
    );

    mbp_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .room2     (room2),
        .not_empty (not_empty),
        .head      (head)
    );

    assign res_valid   = not_empty;
    assign word        = head.word;
    assign valid_bits  = head.valid_bits;
    assign status      = head.status;
    assign value_count = head.value_count;
    assign final_res   = head.final_res;

endmodule

`default_nettype wire

// ===== rtl/mbp_checker.sv =====
// Port-level checks on the bit packer result channel, bound to the top level.
`default_nettype none

module mbp_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         res_valid,
    input wire logic                         res_stall,
    input wire logic [mbp_pkg::WordBits-1:0] word,
    input wire logic [mbp_pkg::WidthW-1:0]   valid_bits,
    input wire logic [mbp_pkg::StatusW-1:0]  status,
    input wire logic                         final_res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != mbp_pkg::STATUS_OK |-> final_res)
        else $error("error result not marked final");

    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != mbp_pkg::STATUS_OK |-> word == '0 && valid_bits == '0)
        else $error("error result carries data");

    a_ok_bits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == mbp_pkg::STATUS_OK
            |-> valid_bits != '0 && valid_bits <= mbp_pkg::FULL_BITS)
        else $error("bad bit count on packed word");

    a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == mbp_pkg::STATUS_OK && valid_bits < mbp_pkg::FULL_BITS
            |-> final_res)
        else $error("partial word not final");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .word       (word),
    .valid_bits (valid_bits),
    .status     (status),
    .final_res  (final_res)
);

`default_nettype wire
